### rtl/ldc_pkg.sv
// Shared types and widths for the Lambert diffuse coefficient pipeline.
// No dependencies.
`default_nettype none
package ldc_pkg;

  localparam int unsigned CompW = 16;
  localparam int unsigned QW    = 16;
  localparam int unsigned ProdW = 64;
  localparam int unsigned AccW  = ProdW + QW;
  localparam int unsigned RemW  = ProdW + 2 * QW + 1;
  localparam int unsigned FracShift = 30;

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [AccW-1:0]  acc;
    logic [ProdW-1:0] prod;
    logic [QW-1:0]    q;
    logic             degen;
  } iter_t;

endpackage
`default_nettype wire

### rtl/ldc_front.sv
// Front end: squares and component-wise products, norms and dot, then norm product and dot squared.
// Depends on ldc_pkg.
`default_nettype none
module ldc_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire logic signed [ldc_pkg::CompW-1:0] lx_i,
  input  wire logic signed [ldc_pkg::CompW-1:0] ly_i,
  input  wire logic signed [ldc_pkg::CompW-1:0] lz_i,
  input  wire logic signed [ldc_pkg::CompW-1:0] nx_i,
  input  wire logic signed [ldc_pkg::CompW-1:0] ny_i,
  input  wire logic signed [ldc_pkg::CompW-1:0] nz_i,
  output logic                               valid_o,
  output ldc_pkg::iter_t                     data_o
);
  import ldc_pkg::*;

  logic signed [31:0] sq_d [9];
  logic signed [31:0] sq_q [9];
  logic               v1_q, v2_q, v3_q;
  logic [31:0]        ll_d, nn_d, ll_q, nn_q;
  logic signed [33:0] dot_d, dot_q;
  logic               pos;
  logic [31:0]        adot;
  logic [ProdW-1:0]   prod_d, d2_d;
  iter_t              out_d, out_q;

  always_comb begin
    sq_d[0] = 32'(lx_i) * 32'(lx_i);
    sq_d[1] = 32'(ly_i) * 32'(ly_i);
    sq_d[2] = 32'(lz_i) * 32'(lz_i);
    sq_d[3] = 32'(nx_i) * 32'(nx_i);
    sq_d[4] = 32'(ny_i) * 32'(ny_i);
    sq_d[5] = 32'(nz_i) * 32'(nz_i);
    sq_d[6] = 32'(lx_i) * 32'(nx_i);
    sq_d[7] = 32'(ly_i) * 32'(ny_i);
    sq_d[8] = 32'(lz_i) * 32'(nz_i);
    ll_d  = 32'(sq_q[0]) + 32'(sq_q[1]) + 32'(sq_q[2]);
    nn_d  = 32'(sq_q[3]) + 32'(sq_q[4]) + 32'(sq_q[5]);
    dot_d = 34'(sq_q[6]) + 34'(sq_q[7]) + 34'(sq_q[8]);
    pos   = (dot_q > 34'sd0);
    adot  = pos ? dot_q[31:0] : 32'd0;
    prod_d = ProdW'(ll_q) * ProdW'(nn_q);
    d2_d   = ProdW'(adot) * ProdW'(adot);
    out_d.degen = (ll_q == 32'd0) || (nn_q == 32'd0);
    out_d.prod  = prod_d;
    out_d.rem   = RemW'(d2_d) << FracShift;
    out_d.acc   = '0;
    out_d.q     = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q  <= sq_d;
      ll_q  <= ll_d;
      nn_q  <= nn_d;
      dot_q <= dot_d;
      out_q <= out_d;
    end
  end

  assign valid_o = v3_q;
  assign data_o  = out_q;

endmodule
`default_nettype wire

### rtl/ldc_step.sv
// One restoring square-root step: settle one result bit by a wide subtract and compare.
// Depends on ldc_pkg.
`default_nettype none
module ldc_step #(
  parameter int unsigned Bit = 0
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire ldc_pkg::iter_t data_i,
  output logic                valid_o,
  output ldc_pkg::iter_t      data_o
);
  import ldc_pkg::*;

  logic [RemW-1:0] term;
  logic [RemW:0]   diff;
  iter_t           data_d, data_q;
  logic            valid_q;

  always_comb begin
    term = (RemW'(data_i.acc) << (Bit + 1)) + (RemW'(data_i.prod) << (2 * Bit));
    diff = {1'b0, data_i.rem} - {1'b0, term};
    data_d = data_i;
    if (!diff[RemW]) begin
      data_d.rem = diff[RemW-1:0];
      data_d.acc = data_i.acc + (AccW'(data_i.prod) << Bit);
      data_d.q   = data_i.q | (QW'(1) << Bit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

### rtl/lambert_diffuse_coefficient.sv
// Top level of the Lambert diffuse coefficient pipeline.
// Depends on ldc_pkg, ldc_front and ldc_step.
//
// Takes one light/normal pair per cycle and returns the clamped cosine
// between them as unsigned Q1.15, truncated toward zero. The pipeline has
// three front stages (multiplies, sums, norm and dot products), one
// square-root stage per result bit (16) and an output register. Throughput
// is one transaction per cycle; the whole pipeline holds while the output
// transaction is stalled. A zero-length vector gives 0 with the degenerate
// flag set.
`default_nettype none
module lambert_diffuse_coefficient (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // light_x, light_y, light_z, normal_x, normal_y, normal_z
  input  wire logic [95:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // diffuse
  output logic [15:0]      m_axis_tdata,
  // degenerate
  output logic             m_axis_tuser
);
  import ldc_pkg::*;

  logic        en;
  logic        valid [QW+1];
  iter_t       data  [QW+1];
  logic        out_valid_q;
  logic [15:0] diffuse_q;
  logic        degen_q;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  ldc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .lx_i    (s_axis_tdata[15:0]),
    .ly_i    (s_axis_tdata[31:16]),
    .lz_i    (s_axis_tdata[47:32]),
    .nx_i    (s_axis_tdata[63:48]),
    .ny_i    (s_axis_tdata[79:64]),
    .nz_i    (s_axis_tdata[95:80]),
    .valid_o (valid[0]),
    .data_o  (data[0])
  );

  for (genvar i = 0; i < QW; i++) begin : g_step
    ldc_step #(
      .Bit (QW - 1 - i)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid[i]),
      .data_i  (data[i]),
      .valid_o (valid[i+1]),
      .data_o  (data[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= valid[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      diffuse_q <= data[QW].degen ? 16'd0 : data[QW].q;
      degen_q   <= data[QW].degen;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = diffuse_q;
  assign m_axis_tuser  = degen_q;

endmodule
`default_nettype wire

### tb/ldc_checker.sv
// Checker for the Lambert diffuse coefficient block: watches both streams,
// predicts the clamped cosine for each accepted input and compares in order.
// Standalone; no dependencies.
module ldc_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [95:0] in_data_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [15:0] out_data_i,
  input  wire logic        out_user_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               seen_o
);

  typedef struct packed {
    logic [15:0] diffuse;
    logic        degenerate;
  } shade_t;

  shade_t cosines_q[$];

  function automatic shade_t lambert_cosine(logic [95:0] d);
    shade_t r;
    logic signed [15:0] c [6];
    logic signed [63:0] v [6];
    logic [63:0] ll, nn, d2;
    logic signed [63:0] dotp;
    logic [127:0] rhs;
    logic [15:0] q;
    logic [16:0] t;
    for (int i = 0; i < 6; i++) begin
      c[i] = d[16*i +: 16];
      v[i] = c[i];
    end
    ll = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
    nn = v[3]*v[3] + v[4]*v[4] + v[5]*v[5];
    dotp = v[0]*v[3] + v[1]*v[4] + v[2]*v[5];
    r = '0;
    if (ll == 0 || nn == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    q = 0;
    if (dotp > 0) begin
      d2 = dotp * dotp;
      rhs = {64'd0, d2} << 30;
      for (int b = 15; b >= 0; b--) begin
        t = {1'b0, q} | (17'd1 << b);
        if ({96'd0, t} * {96'd0, t} * {64'd0, ll * nn} <= rhs) q = t[15:0];
      end
      r.diffuse = q > 16'd32768 ? 16'd32768 : q;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    seen_o = 0;
  end

  assign pending_o = cosines_q.size();

  always @(posedge clk_i) begin
    shade_t e;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) cosines_q.push_back(lambert_cosine(in_data_i));
      if (out_valid_i && out_ready_i) begin
        seen_o++;
        if (cosines_q.size() == 0) begin
          report_mismatch("unexpected transaction", 1, 0);
        end else begin
          e = cosines_q.pop_front();
          if (out_data_i !== e.diffuse) report_mismatch("diffuse", out_data_i, e.diffuse);
          if (out_user_i !== e.degenerate)
            report_mismatch("degenerate", out_user_i, e.degenerate);
        end
      end
    end
  end

endmodule

### tb/lambert_diffuse_coefficient_tb.sv
// Stimulus and verdict for lambert_diffuse_coefficient; directed vectors then
// random light/normal pairs with random gaps on both streams.
// Depends on the block RTL and ldc_checker.
module lambert_diffuse_coefficient_tb;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  int          fail_count, pending, seen;

  lambert_diffuse_coefficient dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  ldc_checker checker_i (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_i(s_axis_tready), .in_data_i(s_axis_tdata),
    .out_valid_i(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_data_i(m_axis_tdata), .out_user_i(m_axis_tuser),
    .fail_count_o(fail_count), .pending_o(pending), .seen_o(seen)
  );

  initial forever #4 clk_i = ~clk_i;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(signed'($urandom_range(0, 16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [95:0] rand_pair();
    logic [47:0] l, n;
    int k;
    l = {rand_comp(), rand_comp(), rand_comp()};
    n = {rand_comp(), rand_comp(), rand_comp()};
    k = $urandom_range(0, 9);
    if (k == 0) n = l;
    else if (k == 1) n = {l[47:32] << 1, l[31:16] << 1, l[15:0] << 1};
    else if (k == 2) n = {-l[47:32], -l[31:16], -l[15:0]};
    else if (k == 3) l = '0;
    return {n, l};
  endfunction

  task automatic send_pair(logic [95:0] d);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tdata  <= d;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // sink side stalls
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      if (g > 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    logic [95:0] directed [$];
    int wait_cycles;
    directed = '{
      {48'h0, 48'h0},
      {48'h0001_0000_0000, 48'h0},
      {48'h0, 48'h0000_0000_0100},
      {48'h0000_0000_0100, 48'h0000_0000_0100},
      {48'h0000_0000_7fff, 48'h0000_0000_0001},
      {48'h8000_8000_8000, 48'h8000_8000_8000},
      {48'h7fff_7fff_7fff, 48'h7fff_7fff_7fff},
      {48'h7fff_7fff_7fff, 48'h8000_8000_8000},
      {48'h8001_8001_8001, 48'h7fff_7fff_7fff},
      {48'h0000_0100_0000, 48'h0000_0000_0100},
      {48'h0000_0000_ff00, 48'h0000_0000_0100},
      {48'h0000_0100_0100, 48'h0000_0000_0100},
      {48'hffff_ffff_ffff, 48'hffff_ffff_ffff},
      {48'h0001_0001_0001, 48'h7fff_7fff_8000},
      {48'h8000_0000_0000, 48'h0001_0000_0000},
      {48'h0003_0004_0000, 48'h0004_0003_0000},
      {48'h5555_aaaa_5555, 48'haaaa_5555_aaaa},
      {48'h0000_0001_0000, 48'h0001_0001_0001}
    };
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed[i]) send_pair(directed[i]);
    for (int i = 0; i < 700; i++) send_pair(rand_pair());
    s_axis_tvalid <= 1'b0;
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 20000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (30) @(posedge clk_i);
    $display("covered %0d directed and 700 random pairs, %0d results checked",
             directed.size(), seen);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
